// ----- rtl/lis_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the longest increasing subsequence search
// no dependencies
package lis_pkg;

	localparam int MAX_LEN     = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int VALUE_PORT_W = 32;
	localparam int LEN_W       = 11;
	localparam int CNT_W       = $clog2(MAX_LEN + 1);
	localparam int ADDR_W      = $clog2(MAX_LEN);

	// flipping the sign bit gives offset binary, so unsigned compare is signed order
	localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef logic [VALUE_WIDTH-1:0] key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_PROBE,
		ST_WRITE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             done_res;
		logic             overflow;
	} res_t;

endpackage

// ----- rtl/lis_cmp.sv -----
`timescale 1ns / 1ps
// shared key comparator used by every probe of the tails store
// depends on lis_pkg
module lis_cmp (
	input  lis_pkg::key_t tail_key,
	input  lis_pkg::key_t item_key,
	output logic          less
);
	import lis_pkg::*;

	// keys are offset binary, plain unsigned compare
	assign less = (tail_key < item_key);

endmodule

// ----- rtl/lis_search.sv -----
`timescale 1ns / 1ps
// sequencer, tails memory and bisection registers of the subsequence search
// depends on lis_pkg and lis_cmp
module lis_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lis_pkg::key_t key,
	input  logic          last,
	input  logic          out_free,
	output logic          ready,
	output logic          res_valid,
	output lis_pkg::res_t res
);
	import lis_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic              ovf_q;
	key_t              key_q;
	logic              last_q;
	logic [ADDR_W-1:0] mid_q, lo_q, hi_q, widx_q;
	logic              append_q;
	key_t              rdata_q;
	key_t              mem [MAX_LEN];

	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] nlo, nhi, mid_next;
	logic              less;
	logic              full;
	logic              mem_we;

	lis_cmp u_cmp (
		.tail_key (rdata_q),
		.item_key (key_q),
		.less     (less)
	);

	assign cnt_m1 = count_q - CNT_W'(1);
	assign full   = (count_q == CNT_W'(MAX_LEN));

	// one bisection step; from the last-tail check the range is every filled tail
	always_comb begin
		if (state_q == ST_LAST) begin
			nlo = '0;
			nhi = mid_q;
		end else if (less) begin
			nlo = mid_q + ADDR_W'(1);
			nhi = hi_q;
		end else begin
			nlo = lo_q;
			nhi = mid_q;
		end
		mid_next = nlo + ((nhi - nlo) >> 1);
	end

	always_comb begin
		case (state_q)
			ST_IDLE:  raddr = cnt_m1[ADDR_W-1:0];
			ST_LAST,
			ST_PROBE: raddr = mid_next;
			default:  raddr = mid_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (count_q == '0) ? ST_WRITE : ST_LAST;
				end
			end
			ST_LAST: begin
				if (less) begin
					state_d = full ? ST_RESULT : ST_WRITE;
				end else begin
					state_d = (nlo == nhi) ? ST_WRITE : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (nlo == nhi) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ready     = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESULT) && out_free;
		mem_we    = (state_q == ST_WRITE);
		res.length   = LEN_W'(count_q);
		res.done_res = last_q;
		res.overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LAST && less && full) begin
				ovf_q <= 1'b1;
			end
			if (state_q == ST_WRITE && append_q) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (res_valid && last_q) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_q    <= key;
					last_q   <= last;
					mid_q    <= cnt_m1[ADDR_W-1:0];
					widx_q   <= count_q[ADDR_W-1:0];
					append_q <= (count_q == '0);
				end
			end
			ST_LAST: begin
				if (less) begin
					append_q <= 1'b1;
					widx_q   <= count_q[ADDR_W-1:0];
				end else begin
					append_q <= 1'b0;
					lo_q     <= nlo;
					hi_q     <= nhi;
					mid_q    <= mid_next;
					widx_q   <= nlo;
				end
			end
			ST_PROBE: begin
				lo_q   <= nlo;
				hi_q   <= nhi;
				mid_q  <= mid_next;
				widx_q <= nlo;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[widx_q] <= key_q;
		end
		rdata_q <= mem[raddr];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("tails count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (lo_q <= mid_q && mid_q < hi_q))
		else $error("probe address outside search range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !append_q) |-> ({1'b0, widx_q} < count_q))
		else $error("replacement beyond filled tails");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && append_q) |-> (!full && widx_q == count_q[ADDR_W-1:0]))
		else $error("append at wrong slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_q) |=> (count_q == '0 && !ovf_q))
		else $error("sequence close did not clear state");

endmodule

// ----- rtl/lis_length_tails_search_top.sv -----
`timescale 1ns / 1ps
// top level of the longest increasing subsequence length search
//
// input channel: value, last with in_valid / in_stall; output channel:
// length, done_res, overflow with out_valid / out_stall. an item is taken
// at a clock edge with valid high and stall low.
// each item gives exactly one result: the running subsequence length, a
// copy of last, and a sticky overflow flag for the current sequence.
// the block handles one item at a time. an append runs the last-tail
// check, then the write; the first item of a sequence goes straight to
// the write, and an append dropped on a full store goes from the check
// straight to the result. a replacement runs the check, then the
// bisection probes, at most ceil(log2(count)) of them (10 with a full
// 1024 entry store), then the write. the tails memory has one registered
// read port, one probe per cycle. the result lands in an output register
// at the same edge at which the block returns to idle and can accept again.
// while a result waits under out_stall the block still accepts and works
// on the next item, then holds it until the output register frees.
// reset clears the tails count, the overflow flag and both valids; the
// tails memory is not cleared, entries are only used once written.
// depends on lis_pkg, lis_search, lis_cmp
module lis_length_tails_search_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lis_pkg::VALUE_PORT_W-1:0] value,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lis_pkg::LEN_W-1:0]        length,
	output logic                             done_res,
	output logic                             overflow
);
	import lis_pkg::*;

	logic  ready;
	logic  start;
	logic  out_free;
	logic  res_valid;
	res_t  res;
	key_t  key;
	logic  out_valid_q;
	res_t  out_q;

	assign in_stall = !ready;
	assign start    = in_valid && ready;
	assign key      = value[VALUE_WIDTH-1:0] ^ SIGN_FLIP;
	assign out_free = !out_valid_q || !out_stall;

	lis_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.key       (key),
		.last      (last),
		.out_free  (out_free),
		.ready     (ready),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign length    = out_q.length;
	assign done_res  = out_q.done_res;
	assign overflow  = out_q.overflow;

endmodule
